/* hw/rtl/iee_pkg.sv */
`default_nettype none

package iee_pkg;

	// token kinds on the mode field
	localparam logic [2:0] MODE_NUM     = 3'd0;
	localparam logic [2:0] MODE_ADD     = 3'd1;
	localparam logic [2:0] MODE_SUB     = 3'd2;
	localparam logic [2:0] MODE_MUL     = 3'd3;
	localparam logic [2:0] MODE_OPEN    = 3'd4;
	localparam logic [2:0] MODE_CLOSE   = 3'd5;

	// operator stack entry codes
	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_SUB  = 2'd1;
	localparam logic [1:0] OP_MUL  = 2'd2;
	localparam logic [1:0] OP_OPEN = 2'd3;

	// result status codes, lower nonzero code wins
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_INVALID   = 3'd1;
	localparam logic [2:0] ST_PAREN     = 3'd2;
	localparam logic [2:0] ST_MALFORMED = 3'd3;
	localparam logic [2:0] ST_OVERFLOW  = 3'd4;

	// operator stack request
	typedef struct packed {
		logic       push;
		logic [1:0] data;
		logic       rd;
	} op_cmd_t;

	// value stack request
	typedef struct packed {
		logic        push;
		logic [31:0] data;
		logic        rd;
		logic        apply;
		logic [1:0]  op;
	} val_cmd_t;

	// keep the error of highest priority
	function automatic logic [2:0] merge_err(input logic [2:0] cur, input logic [2:0] code);
		merge_err = ((cur == ST_OK) || (code < cur)) ? code : cur;
	endfunction

	// precedence: multiply binds tighter than add and subtract
	function automatic logic prec(input logic [1:0] op);
		prec = op[1];
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/iee_op_stack.sv */
`default_nettype none

module iee_op_stack import iee_pkg::*; #(
	parameter  int STACK_DEPTH = 16,
	localparam int AW = $clog2(STACK_DEPTH)
) (
	input  wire logic          clk,
	input  wire op_cmd_t       cmd,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [AW-1:0] rd_addr,
	output logic [1:0]         rdata
);

	logic [1:0] mem [STACK_DEPTH];
	logic [1:0] rdata_q;

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_addr] <= cmd.data;
		end
		if (cmd.rd) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/iee_val_stack.sv */
`default_nettype none

module iee_val_stack import iee_pkg::*; #(
	parameter  int STACK_DEPTH = 16,
	localparam int AW = $clog2(STACK_DEPTH)
) (
	input  wire logic          clk,
	input  wire val_cmd_t      cmd,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [AW-1:0] rd_addr,
	output logic [31:0]        top
);

	logic [31:0] mem [STACK_DEPTH];
	logic [31:0] rdata_q;   // second value from the top
	logic [31:0] top_q;     // copy of the top entry
	logic [31:0] prod;
	logic [31:0] res;

	// low word of the product, wraps at 32 bits
	assign prod = rdata_q * top_q;

	always_comb begin
		unique case (cmd.op)
			OP_ADD:  res = rdata_q + top_q;
			OP_SUB:  res = rdata_q - top_q;
			default: res = prod;
		endcase
	end

	// push or write back the reduced value; top copy follows the memory
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_addr] <= cmd.data;
			top_q        <= cmd.data;
		end else if (cmd.apply) begin
			mem[wr_addr] <= res;
			top_q        <= res;
		end
		if (cmd.rd) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign top = top_q;

endmodule

`default_nettype wire

/* hw/rtl/infix_expression_evaluator.sv */
// Infix integer expression evaluator. Tokens arrive one item at a time on the
// token channel (number, +, -, *, parentheses, invalid); operators are reduced
// by precedence, left-associative, with 32-bit wrapping arithmetic, and the
// token marked final yields one result item with answer and status (answer is
// zero on any error). Both stacks live in synchronous memories with one write
// port and one registered read port, and a sequencer serialises every access,
// so no read ever meets a write to the same entry. A number, open, invalid
// token, or an operator or close meeting an empty operator stack is handled in
// the dispatch state alone; an operator or close that must look at the stack
// first reads the top operator, and each operator popped is applied by reading
// it, reading the second value and writing back, while one that lacks operands
// is discarded. The open that ends a close finishes the token. The final token
// then applies or discards every remaining operator (an open left behind
// counts as discarded) before the result is formed, and holds while an earlier
// result item is still stalled.
// The token channel stalls while a token is in work; a finished result waits
// in its own register while the next token is taken.
`default_nettype none

module infix_expression_evaluator import iee_pkg::*; #(
	parameter int STACK_DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               token_valid,
	output logic                    token_stall,
	input  wire logic        [2:0]  mode,
	input  wire logic signed [31:0] operand,
	input  wire logic               final_token,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic signed [31:0]      answer,
	output logic        [2:0]       status
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DISP  = 3'd1;
	localparam logic [2:0] S_LOOP  = 3'd2;
	localparam logic [2:0] S_OTEST = 3'd3;
	localparam logic [2:0] S_APPLY = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	// what the pop loop is doing
	localparam logic [1:0] PH_OP    = 2'd0;
	localparam logic [1:0] PH_CLOSE = 2'd1;
	localparam logic [1:0] PH_DRAIN = 2'd2;

	logic [2:0]    state_q, state_d;
	logic [1:0]    phase_q, phase_d;
	logic [CW-1:0] ocnt_q, ocnt_d;
	logic [CW-1:0] vcnt_q, vcnt_d;
	logic [2:0]    err_q, err_d;
	logic          rvalid_q, rvalid_d;

	logic [2:0]    mode_q;
	logic [31:0]   operand_q;
	logic          final_q;
	logic [1:0]    apply_op_q, apply_op_d;
	logic [31:0]   ans_q, ans_d;
	logic [2:0]    stat_q, stat_d;
	logic          load_res;

	op_cmd_t       ocmd;
	val_cmd_t      vcmd;
	logic [AW-1:0] o_waddr, o_raddr, v_waddr, v_raddr;
	logic [1:0]    o_rdata;
	logic [31:0]   v_top;

	logic          accept;
	logic [CW-1:0] ocnt_m1, vcnt_m2;
	logic [1:0]    tok_op;
	logic          is_op;

	assign accept  = token_valid && !token_stall;
	assign ocnt_m1 = ocnt_q - CW'(1);
	assign vcnt_m2 = vcnt_q - CW'(2);
	assign tok_op  = 2'(mode_q - MODE_ADD);
	assign is_op   = (mode_q == MODE_ADD) || (mode_q == MODE_SUB) || (mode_q == MODE_MUL);

	// sequencer
	always_comb begin
		logic [1:0] ph;
		logic       do_loop;
		logic       tok_done;
		logic       push_op;
		logic [1:0] push_code;
		logic [2:0] fin_err;

		state_d    = state_q;
		phase_d    = phase_q;
		ocnt_d     = ocnt_q;
		vcnt_d     = vcnt_q;
		err_d      = err_q;
		apply_op_d = apply_op_q;
		ans_d      = ans_q;
		stat_d     = stat_q;
		load_res   = 1'b0;
		rvalid_d   = rvalid_q && result_stall;
		ocmd       = '0;
		vcmd       = '0;
		vcmd.data  = operand_q;
		vcmd.op    = apply_op_q;
		o_waddr    = ocnt_q[AW-1:0];
		o_raddr    = ocnt_m1[AW-1:0];
		v_waddr    = vcnt_q[AW-1:0];
		v_raddr    = vcnt_m2[AW-1:0];
		ph         = phase_q;
		do_loop    = 1'b0;
		tok_done   = 1'b0;
		push_op    = 1'b0;
		push_code  = tok_op;
		fin_err    = err_q;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (mode_q == MODE_NUM) begin
					if (vcnt_q >= CW'(STACK_DEPTH)) begin
						err_d = merge_err(err_d, ST_OVERFLOW);
					end else begin
						vcmd.push = 1'b1;
						vcnt_d    = vcnt_q + CW'(1);
					end
					tok_done = 1'b1;
				end else if (is_op) begin
					ph      = PH_OP;
					phase_d = PH_OP;
					do_loop = 1'b1;
				end else if (mode_q == MODE_OPEN) begin
					push_op   = 1'b1;
					push_code = OP_OPEN;
					tok_done  = 1'b1;
				end else if (mode_q == MODE_CLOSE) begin
					ph      = PH_CLOSE;
					phase_d = PH_CLOSE;
					do_loop = 1'b1;
				end else begin
					err_d    = merge_err(err_d, ST_INVALID);
					tok_done = 1'b1;
				end
			end
			S_LOOP: begin
				do_loop = 1'b1;
			end
			S_OTEST: begin
				if ((phase_q == PH_OP) &&
				    ((o_rdata == OP_OPEN) || (prec(o_rdata) < prec(tok_op)))) begin
					push_op  = 1'b1;
					tok_done = 1'b1;
				end else begin
					ocnt_d = ocnt_m1;
					if (o_rdata == OP_OPEN) begin
						if (phase_q == PH_CLOSE) begin
							tok_done = 1'b1;
						end else begin
							err_d   = merge_err(err_d, ST_PAREN);
							state_d = S_LOOP;
						end
					end else if (vcnt_q < CW'(2)) begin
						err_d   = merge_err(err_d, ST_MALFORMED);
						state_d = S_LOOP;
					end else begin
						vcmd.rd    = 1'b1;
						apply_op_d = o_rdata;
						state_d    = S_APPLY;
					end
				end
			end
			S_APPLY: begin
				vcmd.apply = 1'b1;
				v_waddr    = vcnt_m2[AW-1:0];
				vcnt_d     = vcnt_q - CW'(1);
				state_d    = S_LOOP;
			end
			S_FIN: begin
				if (vcnt_q != CW'(1)) begin
					fin_err = merge_err(err_q, ST_MALFORMED);
				end
				if (!rvalid_q || !result_stall) begin
					load_res = 1'b1;
					ans_d    = (fin_err == ST_OK) ? v_top : 32'd0;
					stat_d   = fin_err;
					rvalid_d = 1'b1;
					ocnt_d   = '0;
					vcnt_d   = '0;
					err_d    = ST_OK;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// one step of the pop loop: look at the top operator or finish
		if (do_loop) begin
			if (ocnt_q != '0) begin
				ocmd.rd = 1'b1;
				state_d = S_OTEST;
			end else begin
				unique case (ph)
					PH_OP: begin
						push_op  = 1'b1;
						tok_done = 1'b1;
					end
					PH_CLOSE: begin
						err_d    = merge_err(err_d, ST_PAREN);
						tok_done = 1'b1;
					end
					default: begin
						state_d = S_FIN;
					end
				endcase
			end
		end

		// operator push, dropped when full
		if (push_op) begin
			if (ocnt_q >= CW'(STACK_DEPTH)) begin
				err_d = merge_err(err_d, ST_OVERFLOW);
			end else begin
				ocmd.push = 1'b1;
				ocmd.data = push_code;
				ocnt_d    = ocnt_q + CW'(1);
			end
		end

		// token handled: drain on the final one, else take the next
		if (tok_done) begin
			if (final_q) begin
				phase_d = PH_DRAIN;
				state_d = S_LOOP;
			end else begin
				state_d = S_IDLE;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			phase_q  <= PH_OP;
			ocnt_q   <= '0;
			vcnt_q   <= '0;
			err_q    <= ST_OK;
			rvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			ocnt_q   <= ocnt_d;
			vcnt_q   <= vcnt_d;
			err_q    <= err_d;
			rvalid_q <= rvalid_d;
		end
	end

	// token and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q    <= mode;
			operand_q <= $unsigned(operand);
			final_q   <= final_token;
		end
		apply_op_q <= apply_op_d;
		if (load_res) begin
			ans_q  <= ans_d;
			stat_q <= stat_d;
		end
	end

	iee_op_stack #(.STACK_DEPTH(STACK_DEPTH)) u_op_stack (
		.clk     (clk),
		.cmd     (ocmd),
		.wr_addr (o_waddr),
		.rd_addr (o_raddr),
		.rdata   (o_rdata)
	);

	iee_val_stack #(.STACK_DEPTH(STACK_DEPTH)) u_val_stack (
		.clk     (clk),
		.cmd     (vcmd),
		.wr_addr (v_waddr),
		.rd_addr (v_raddr),
		.top     (v_top)
	);

	assign token_stall  = (state_q != S_IDLE);
	assign result_valid = rvalid_q;
	assign answer       = $signed(ans_q);
	assign status       = stat_q;

endmodule

`default_nettype wire

/* hw/rtl/iee_checker.sv */
`default_nettype none

module iee_checker import iee_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               token_valid,
	input wire logic               token_stall,
	input wire logic        [2:0]  mode,
	input wire logic signed [31:0] operand,
	input wire logic               final_token,
	input wire logic               result_valid,
	input wire logic               result_stall,
	input wire logic signed [31:0] answer,
	input wire logic        [2:0]  status
);

	// a stalled token item is held until taken
	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> token_valid && $stable(mode) &&
		$stable(operand) && $stable(final_token))
		else $error("token item dropped or changed while stalled");

	// a waiting result item is held until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(answer) && $stable(status))
		else $error("result item dropped or changed while stalled");

	// status stays within its codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> status <= ST_OVERFLOW)
		else $error("status code out of range");

	// an errored expression reports a zero answer
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != ST_OK) |-> answer == 32'sd0)
		else $error("nonzero answer with error status");

	// an accepted token is always followed by a stalled token channel
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !token_stall |=> token_stall)
		else $error("token channel open right after an accepted item");

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (.*);

`default_nettype wire
